/* hw/rtl/nlls_pkg.sv */
// ----------------------------------------------------------------------------
// nlls_pkg: shared types and constants of the in-lane leader search
// Field widths, configuration register indexes, reset values, payload
// structs and the control state type used across the block.
// ----------------------------------------------------------------------------
package nlls_pkg;

	localparam int POSITION_BITS = 24;
	localparam int ID_BITS       = 8;

	localparam int LANE_NUM_BITS = 3;
	localparam int LANE_W_BITS   = 12;
	localparam int TIME_BITS     = 12;
	localparam int LAT_BITS      = 15;
	localparam int SPEED_BITS    = 21;
	localparam int EGO_BITS      = POSITION_BITS + 1;
	localparam int FRAC_BITS     = 8;

	// Lane limit compare: (10*lane+14)*width stays below 2^21.
	localparam int LANE_CMP_BITS = 22;

	// Time is unsigned, so it takes one extra bit as a signed factor.
	localparam int PROD_BITS  = TIME_BITS + 1 + SPEED_BITS;
	localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
	localparam int WIDE_BITS  = (EGO_BITS > SHIFT_BITS) ? EGO_BITS : SHIFT_BITS;
	localparam int DIFF_BITS  = WIDE_BITS + 2;
	localparam int CNT_BITS   = $clog2(DIFF_BITS + 1);

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = EGO_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_LANE_NUMBER     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LANE_WIDTH      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_LEN        = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_EGO_POSITION    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOK_AHEAD_TIME = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SEARCH_RANGE    = 3'd5;

	localparam logic [LANE_NUM_BITS-1:0] RST_LANE_NUMBER = 3'd1;
	localparam logic [LANE_W_BITS-1:0]   RST_LANE_WIDTH  = 12'd1024;
	localparam logic [POSITION_BITS-1:0] RST_LOOP_LEN    = POSITION_BITS'(1778062);

	typedef struct packed {
		logic [POSITION_BITS-1:0] obstacle_along;
		logic [LAT_BITS-1:0]      obstacle_lateral;
		logic [SPEED_BITS-1:0]    obstacle_speed;
		logic [ID_BITS-1:0]       obstacle_id;
		logic                     last_obstacle;
	} in_item_t;

	typedef struct packed {
		logic                     found;
		logic [ID_BITS-1:0]       nearest_id;
		logic [POSITION_BITS-1:0] nearest_distance;
	} out_item_t;

	typedef struct packed {
		logic [LANE_NUM_BITS-1:0] lane_number;
		logic [LANE_W_BITS-1:0]   lane_width;
		logic [POSITION_BITS-1:0] loop_len;
		logic [EGO_BITS-1:0]      ego_position;
		logic [TIME_BITS-1:0]     look_ahead_time;
		logic [POSITION_BITS-1:0] search_range;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} front_ctl_t;

	typedef struct packed {
		logic               lane_ok;
		logic [ID_BITS-1:0] id;
		logic               last;
	} item_tag_t;

	typedef struct packed {
		logic                     done;
		logic [POSITION_BITS-1:0] ahead;
	} rem_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_UPD
	} state_t;

endpackage

/* hw/rtl/nlls_front.sv */
// ----------------------------------------------------------------------------
// nlls_front: lane test and position prediction
// Stage 1 checks the lateral offset against the widened lane limits and
// forms speed times look-ahead time. Stage 2 gives the signed along-road
// offset from the ego vehicle, before reduction to the track length.
// ----------------------------------------------------------------------------
module nlls_front import nlls_pkg::*; (
	input  logic                        clk,
	input  front_ctl_t                  ctl,
	input  in_item_t                    item,
	input  cfg_t                        cfg,
	output logic signed [DIFF_BITS-1:0] diff,
	output item_tag_t                   tag
);

	localparam logic signed [LANE_CMP_BITS-1:0] K_TEN      = LANE_CMP_BITS'(10);
	localparam logic signed [LANE_CMP_BITS-1:0] K_FOUR     = LANE_CMP_BITS'(4);
	localparam logic signed [LANE_CMP_BITS-1:0] K_FOURTEEN = LANE_CMP_BITS'(14);

	logic signed [LANE_CMP_BITS-1:0] lat_x, ln_x, w_x, d10, lo, hi;
	logic                            lane_ok;
	logic signed [PROD_BITS-1:0]     time_x, speed_x, prod;
	logic signed [SHIFT_BITS-1:0]    shifted;
	logic signed [DIFF_BITS-1:0]     along_x, shift_x, ego_x;

	logic signed [PROD_BITS-1:0]     prod_s1;
	logic [POSITION_BITS-1:0]        along_s1;
	item_tag_t                       tag_s1;
	logic signed [DIFF_BITS-1:0]     diff_s2;
	item_tag_t                       tag_s2;

	always_comb begin
		lat_x = {{(LANE_CMP_BITS-LAT_BITS){item.obstacle_lateral[LAT_BITS-1]}},
			item.obstacle_lateral};
		ln_x  = LANE_CMP_BITS'(cfg.lane_number);
		w_x   = LANE_CMP_BITS'(cfg.lane_width);
		d10   = lat_x * K_TEN;
		lo    = (ln_x * K_TEN - K_FOUR) * w_x;
		hi    = (ln_x * K_TEN + K_FOURTEEN) * w_x;
		lane_ok = (d10 >= lo) && (d10 <= hi);

		time_x  = PROD_BITS'(cfg.look_ahead_time);
		speed_x = {{(PROD_BITS-SPEED_BITS){item.obstacle_speed[SPEED_BITS-1]}},
			item.obstacle_speed};
		prod    = time_x * speed_x;
	end

	// Dropping the fraction bits of a two's complement product floors it.
	always_comb begin
		shifted = prod_s1[PROD_BITS-1:FRAC_BITS];
		along_x = DIFF_BITS'(along_s1);
		shift_x = {{(DIFF_BITS-SHIFT_BITS){shifted[SHIFT_BITS-1]}}, shifted};
		ego_x   = {{(DIFF_BITS-EGO_BITS){cfg.ego_position[EGO_BITS-1]}},
			cfg.ego_position};
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			prod_s1        <= prod;
			along_s1       <= item.obstacle_along;
			tag_s1.lane_ok <= lane_ok;
			tag_s1.id      <= item.obstacle_id;
			tag_s1.last    <= item.last_obstacle;
		end
		if (ctl.load_s2) begin
			diff_s2 <= along_x + shift_x - ego_x;
			tag_s2  <= tag_s1;
		end
	end

	assign diff = diff_s2;
	assign tag  = tag_s2;

endmodule

/* hw/rtl/nlls_rem.sv */
// ----------------------------------------------------------------------------
// nlls_rem: bit-serial remainder by the track length
// Restoring remainder on the magnitude, one dividend bit per cycle from a
// shift register, then a fix-up step that maps a negative dividend onto
// the nonnegative remainder in [0, length).
// ----------------------------------------------------------------------------
module nlls_rem import nlls_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [DIFF_BITS-1:0] value,
	input  logic [POSITION_BITS-1:0]    modulus,
	output rem_stat_t                   stat
);

	logic                      step_q, fix_q, done_q;
	logic [CNT_BITS-1:0]       cnt_q;
	logic [DIFF_BITS-1:0]      mag_q;
	logic [POSITION_BITS-1:0]  rem_q, dist_q;
	logic                      neg_q;

	logic [POSITION_BITS-1:0]  mod_eff;
	logic [POSITION_BITS:0]    trial, trial_sub;
	logic [DIFF_BITS-1:0]      mag_in;

	// A zero length behaves as a length of one.
	assign mod_eff = (modulus == '0) ? POSITION_BITS'(1) : modulus;

	always_comb begin
		mag_in    = value[DIFF_BITS-1] ? (~value + DIFF_BITS'(1)) : value;
		trial     = {rem_q, mag_q[DIFF_BITS-1]};
		trial_sub = trial - {1'b0, mod_eff};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && !step_q && fix_q;
			if (start) begin
				step_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DIFF_BITS);
			end else if (step_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					step_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag_in;
			neg_q <= value[DIFF_BITS-1];
			rem_q <= '0;
		end else if (step_q) begin
			mag_q <= {mag_q[DIFF_BITS-2:0], 1'b0};
			if (trial >= {1'b0, mod_eff}) begin
				rem_q <= trial_sub[POSITION_BITS-1:0];
			end else begin
				rem_q <= trial[POSITION_BITS-1:0];
			end
		end else if (fix_q) begin
			dist_q <= (neg_q && rem_q != '0) ? (mod_eff - rem_q) : rem_q;
		end
	end

	assign stat.done  = done_q;
	assign stat.ahead = dist_q;

`ifndef SYNTH
	a_fix_after_steps: assert property (@(posedge clk) disable iff (!arst_n)
		fix_q |-> !step_q)
		else $error("remainder fix-up overlaps the shift steps");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		step_q |-> cnt_q != '0)
		else $error("remainder step with an exhausted count");

	a_dist_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> dist_q < mod_eff)
		else $error("remainder not below the track length");
`endif

endmodule

/* hw/rtl/nearest_leader_in_lane_select.sv */
// ----------------------------------------------------------------------------
// nearest_leader_in_lane_select: nearest in-lane obstacle ahead on a loop track
// Top level with the configuration registers, the control sequencer, the
// running best obstacle and the result register.
// ----------------------------------------------------------------------------
// Each obstacle transaction runs from acceptance until the block can accept
// the next one: the lane test and the speed product, then the offset sum,
// then the remainder by the track length, worked one bit per cycle over
// the signed offset, plus a fix-up, a handoff and an update step. Obstacles
// are taken one at a time. A result appears only for the transaction marked
// last; it waits in an output register, so the next scan may start before it
// is taken, and only a second last transaction stalls behind an untaken
// result. Configuration writes take effect at once and belong between scans.
module nearest_leader_in_lane_select import nlls_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  in_item_t                  in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output out_item_t                 out_data,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	state_t                      state_q, state_d;
	cfg_t                        cfg_q;
	front_ctl_t                  front_ctl;
	logic signed [DIFF_BITS-1:0] diff;
	item_tag_t                   tag;
	logic                        rem_start;
	rem_stat_t                   rem_stat;

	logic                        best_have_q;
	logic [ID_BITS-1:0]          best_id_q;
	logic [POSITION_BITS-1:0]    best_dist_q;
	logic                        out_valid_q;
	out_item_t                   out_q;

	logic                        out_free, upd_go, better;
	logic                        new_have;
	logic [ID_BITS-1:0]          new_id;
	logic [POSITION_BITS-1:0]    new_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lane_number     <= RST_LANE_NUMBER;
			cfg_q.lane_width      <= RST_LANE_WIDTH;
			cfg_q.loop_len        <= RST_LOOP_LEN;
			cfg_q.ego_position    <= '0;
			cfg_q.look_ahead_time <= '0;
			cfg_q.search_range    <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LANE_NUMBER:     cfg_q.lane_number     <= cfg_data[LANE_NUM_BITS-1:0];
				CFG_LANE_WIDTH:      cfg_q.lane_width      <= cfg_data[LANE_W_BITS-1:0];
				CFG_LOOP_LEN:        cfg_q.loop_len        <= cfg_data[POSITION_BITS-1:0];
				CFG_EGO_POSITION:    cfg_q.ego_position    <= cfg_data[EGO_BITS-1:0];
				CFG_LOOK_AHEAD_TIME: cfg_q.look_ahead_time <= cfg_data[TIME_BITS-1:0];
				CFG_SEARCH_RANGE:    cfg_q.search_range    <= cfg_data[POSITION_BITS-1:0];
				default: ;
			endcase
		end
	end

	nlls_front u_front (
		.clk  (clk),
		.ctl  (front_ctl),
		.item (in_data),
		.cfg  (cfg_q),
		.diff (diff),
		.tag  (tag)
	);

	nlls_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.value   (diff),
		.modulus (cfg_q.loop_len),
		.stat    (rem_stat)
	);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV:  if (rem_stat.done) state_d = ST_UPD;
			ST_UPD:  if (!tag.last || out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready          = 1'b0;
		front_ctl.load_s1 = 1'b0;
		front_ctl.load_s2 = 1'b0;
		rem_start         = 1'b0;
		upd_go            = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready          = 1'b1;
				front_ctl.load_s1 = in_valid;
			end
			ST_MUL:  front_ctl.load_s2 = 1'b1;
			ST_SUM:  rem_start = 1'b1;
			ST_DIV:  ;
			ST_UPD:  upd_go = !tag.last || out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The earlier obstacle keeps a tie, so only a strictly smaller distance wins.
	always_comb begin
		better = tag.lane_ok && (rem_stat.ahead < cfg_q.search_range) &&
			(!best_have_q || rem_stat.ahead < best_dist_q);
		new_have = best_have_q || better;
		new_id   = better ? tag.id : best_id_q;
		new_dist = better ? rem_stat.ahead : best_dist_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_have_q <= 1'b0;
			best_id_q   <= '0;
			best_dist_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go && tag.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (upd_go) begin
				if (tag.last) begin
					best_have_q <= 1'b0;
					best_id_q   <= '0;
					best_dist_q <= '0;
				end else begin
					best_have_q <= new_have;
					best_id_q   <= new_id;
					best_dist_q <= new_dist;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && tag.last) begin
			out_q.found            <= new_have;
			out_q.nearest_id       <= new_have ? new_id : '0;
			out_q.nearest_distance <= new_have ? new_dist : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_rem_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rem_stat.done |-> state_q == ST_DIV)
		else $error("remainder finished outside its wait state");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPD))
		else $error("result register loaded outside the update state");

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.found |->
			out_q.nearest_id == '0 && out_q.nearest_distance == '0)
		else $error("result without a leader carries nonzero fields");
`endif

endmodule

/* tb/sv/tb_nearest_leader_in_lane_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_leader_in_lane_select: self-checking bench of the in-lane leader search
// Drives scans of obstacles through the block with random gaps on both
// channels, predicts each scan result from its own model of the lane test,
// the look-ahead prediction and the circular distance, and compares every
// result field by field. Directed scans cover lane edges, field extremes,
// ties, wraparound and degenerate settings; random phases sweep the
// registers, and one phase stalls the output long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_nearest_leader_in_lane_select;
	import nlls_pkg::*;

	localparam int RANDOM_PHASES   = 24;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int HOLD_CYCLES     = 300;
	localparam int QUIET_CYCLES    = DIFF_BITS + 10;
	localparam int WATCHDOG_LIMIT  = 4000;

	// Indexes that map to no register; writes to them must change nothing.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	in_item_t                  in_data   = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	out_item_t                 out_data;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	nearest_leader_in_lane_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the registers and of the running scan.
	cfg_t road_cfg = '{
		lane_number:     RST_LANE_NUMBER,
		lane_width:      RST_LANE_WIDTH,
		loop_len:        RST_LOOP_LEN,
		ego_position:    '0,
		look_ahead_time: '0,
		search_range:    '1
	};
	logic [POSITION_BITS-1:0] lead_distance = '0;
	logic [ID_BITS-1:0]       lead_id       = '0;
	bit                       lead_valid    = 1'b0;

	out_item_t expected_results[$];

	int unsigned errors           = 0;
	int unsigned obstacles_sent   = 0;
	int unsigned results_checked  = 0;
	int unsigned settings_applied = 0;
	int unsigned idle_cycles      = 0;
	int unsigned hold_request     = 0;
	bit          sender_eager     = 1'b0;
	bit          receiver_eager   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint wrap_mod(input longint x, input longint len);
		longint m;
		m = x % len;
		if (m < 0)
			m += len;
		return m;
	endfunction

	// Advances the predicted scan by one obstacle; a last obstacle yields a result.
	function automatic void predict_obstacle(input in_item_t ob, output bit emits,
		output out_item_t res);
		longint w, ln, lo, hi, d10, len, ego, s, ahead;
		w   = longint'(road_cfg.lane_width);
		ln  = longint'(road_cfg.lane_number);
		lo  = (10 * ln - 4) * w;
		hi  = (10 * ln + 14) * w;
		d10 = 10 * longint'($signed(ob.obstacle_lateral));
		emits = 1'b0;
		res   = '0;
		if (d10 >= lo && d10 <= hi) begin
			len   = (road_cfg.loop_len == 0) ? 1 : longint'(road_cfg.loop_len);
			ego   = wrap_mod(longint'($signed(road_cfg.ego_position)), len);
			s     = longint'(ob.obstacle_along) + ((longint'(road_cfg.look_ahead_time)
				* longint'($signed(ob.obstacle_speed))) >>> FRAC_BITS);
			ahead = wrap_mod(wrap_mod(s, len) - ego, len);
			if (ahead < longint'(road_cfg.search_range)
				&& (!lead_valid || ahead < longint'(lead_distance))) begin
				lead_distance = POSITION_BITS'(ahead);
				lead_id       = ob.obstacle_id;
				lead_valid    = 1'b1;
			end
		end
		if (ob.last_obstacle) begin
			emits = 1'b1;
			res.found            = lead_valid;
			res.nearest_id       = lead_valid ? lead_id : '0;
			res.nearest_distance = lead_valid ? lead_distance : '0;
			lead_distance = '0;
			lead_id       = '0;
			lead_valid    = 1'b0;
		end
	endfunction

	function automatic in_item_t obstacle_item(input logic [POSITION_BITS-1:0] along,
		input int lat, input int speed, input logic [ID_BITS-1:0] id, input bit last);
		in_item_t ob;
		ob.obstacle_along   = along;
		ob.obstacle_lateral = LAT_BITS'(lat);
		ob.obstacle_speed   = SPEED_BITS'(speed);
		ob.obstacle_id      = id;
		ob.last_obstacle    = last;
		return ob;
	endfunction

	function automatic cfg_t road(input int lane, input int width, input longint track,
		input longint ego, input int ahead, input longint range_limit);
		cfg_t c;
		c.lane_number     = LANE_NUM_BITS'(lane);
		c.lane_width      = LANE_W_BITS'(width);
		c.loop_len        = POSITION_BITS'(track);
		c.ego_position    = EGO_BITS'(ego);
		c.look_ahead_time = TIME_BITS'(ahead);
		c.search_range    = POSITION_BITS'(range_limit);
		return c;
	endfunction

	function automatic longint clamp_lateral(input longint d);
		if (d < -16384)
			return -16384;
		if (d > 16383)
			return 16383;
		return d;
	endfunction

	// Mostly in-lane obstacles, some right at the lane limits, the rest anywhere.
	function automatic in_item_t random_obstacle(input bit last);
		longint lo, hi, dlo, dhi, lat;
		int unsigned pick;
		lo   = (10 * longint'(road_cfg.lane_number) - 4) * longint'(road_cfg.lane_width);
		hi   = (10 * longint'(road_cfg.lane_number) + 14) * longint'(road_cfg.lane_width);
		dlo  = (lo < 0) ? lo / 10 : (lo + 9) / 10;
		dhi  = hi / 10;
		pick = $urandom_range(9);
		if (pick < 6 && clamp_lateral(dlo) <= clamp_lateral(dhi)) begin
			lat = clamp_lateral(dlo) + longint'($urandom_range(
				int'(clamp_lateral(dhi) - clamp_lateral(dlo))));
		end else if (pick < 8) begin
			case ($urandom_range(3))
				0: lat = clamp_lateral(dlo - 1);
				1: lat = clamp_lateral(dlo);
				2: lat = clamp_lateral(dhi);
				default: lat = clamp_lateral(dhi + 1);
			endcase
		end else begin
			lat = longint'($signed(LAT_BITS'($urandom())));
		end
		return obstacle_item(POSITION_BITS'($urandom()), int'(lat), int'($urandom()),
			ID_BITS'($urandom()), last);
	endfunction

	function automatic cfg_t random_road_cfg();
		cfg_t c;
		c.lane_number     = LANE_NUM_BITS'($urandom());
		c.lane_width      = ($urandom_range(3) == 0) ? LANE_W_BITS'($urandom())
			: LANE_W_BITS'($urandom_range(2047, 1));
		case ($urandom_range(3))
			0: c.loop_len = POSITION_BITS'($urandom_range(4096, 1));
			1: c.loop_len = POSITION_BITS'($urandom());
			2: c.loop_len = '1;
			default: c.loop_len = POSITION_BITS'($urandom_range(2000000, 100000));
		endcase
		c.ego_position    = EGO_BITS'($urandom());
		c.look_ahead_time = TIME_BITS'($urandom());
		case ($urandom_range(3))
			0: c.search_range = '1;
			1: c.search_range = POSITION_BITS'($urandom_range(c.loop_len));
			2: c.search_range = POSITION_BITS'($urandom());
			default: c.search_range = POSITION_BITS'($urandom_range(c.loop_len / 4));
		endcase
		return c;
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		write_reg(CFG_LANE_NUMBER, CFG_DATA_BITS'(c.lane_number));
		write_reg(CFG_LANE_WIDTH, CFG_DATA_BITS'(c.lane_width));
		write_reg(CFG_LOOP_LEN, CFG_DATA_BITS'(c.loop_len));
		write_reg(CFG_EGO_POSITION, c.ego_position);
		write_reg(CFG_LOOK_AHEAD_TIME, CFG_DATA_BITS'(c.look_ahead_time));
		write_reg(CFG_SEARCH_RANGE, CFG_DATA_BITS'(c.search_range));
		cfg_we   <= 1'b0;
		road_cfg  = c;
		settings_applied++;
	endtask

	task automatic send_obstacle(input in_item_t ob);
		int unsigned gap;
		bit          emits;
		out_item_t   res;
		gap = sender_eager ? 0 : $urandom_range(14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= ob;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_obstacle(ob, emits, res);
		if (emits)
			expected_results.push_back(res);
		obstacles_sent++;
	endtask

	// The block may still be working on an obstacle that yields no result.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic test_default_lane_limits();
		send_obstacle(obstacle_item(100, 614, 0, 1, 1'b0));
		send_obstacle(obstacle_item(300, 615, 0, 2, 1'b0));
		send_obstacle(obstacle_item(200, 2457, 0, 3, 1'b0));
		send_obstacle(obstacle_item(10, 2458, 0, 4, 1'b1));
		wait_idle();
	endtask

	task automatic test_field_extremes();
		apply_config(road(0, 4095, 24'hFFFFFF, -16777216, 4095, 24'hFFFFFF));
		send_obstacle(obstacle_item(24'hFFFFFF, 0, 1048575, 255, 1'b0));
		send_obstacle(obstacle_item(0, -1638, -1048576, 0, 1'b0));
		send_obstacle(obstacle_item(0, -16384, 0, 128, 1'b0));
		send_obstacle(obstacle_item(123, 16383, -1, 1, 1'b1));
		wait_idle();
	endtask

	task automatic test_outer_lane_wrap();
		apply_config(road(7, 2000, 1000, 16777215, 0, 24'hFFFFFF));
		send_obstacle(obstacle_item(24'hFFFFFF, 16383, 0, 9, 1'b0));
		send_obstacle(obstacle_item(0, 13199, 0, 21, 1'b0));
		send_obstacle(obstacle_item(5, 13200, -1, 33, 1'b1));
		wait_idle();
	endtask

	task automatic test_tie_first_wins();
		apply_config(road(1, 1024, 1778062, 1000, 256, 24'hFFFFFF));
		send_obstacle(obstacle_item(2000, 1000, 0, 10, 1'b0));
		send_obstacle(obstacle_item(1744, 1000, 256, 11, 1'b0));
		send_obstacle(obstacle_item(5000, 1000, 0, 12, 1'b1));
		wait_idle();
	endtask

	task automatic test_zero_track_length();
		apply_config(road(1, 1024, 0, 12345, 100, 24'hFFFFFF));
		send_obstacle(obstacle_item(777, 1000, -5000, 40, 1'b0));
		send_obstacle(obstacle_item(99, 1000, 300, 41, 1'b1));
		wait_idle();
	endtask

	task automatic test_zero_lane_width();
		apply_config(road(0, 0, 1778062, 0, 0, 24'hFFFFFF));
		send_obstacle(obstacle_item(500, 1, 0, 50, 1'b0));
		send_obstacle(obstacle_item(600, -1, 0, 51, 1'b0));
		send_obstacle(obstacle_item(700, 0, 0, 52, 1'b1));
		wait_idle();
	endtask

	task automatic test_search_range_limits();
		apply_config(road(1, 1024, 1778062, 0, 0, 500));
		send_obstacle(obstacle_item(500, 1000, 0, 60, 1'b0));
		send_obstacle(obstacle_item(499, 1000, 0, 61, 1'b1));
		wait_idle();
		apply_config(road(1, 1024, 1778062, 0, 0, 0));
		send_obstacle(obstacle_item(0, 1000, 0, 62, 1'b1));
		wait_idle();
	endtask

	task automatic test_spare_index();
		apply_config(road(1, 1024, 1778062, 0, 0, 24'hFFFFFF));
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, '0);
		cfg_we <= 1'b0;
		send_obstacle(obstacle_item(321, 1000, 0, 70, 1'b1));
		wait_idle();
	endtask

	task automatic test_random_scans();
		int unsigned ph, k, scan_len, sent;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: apply_config(road(7, 4095, 24'hFFFFFF, 16777215, 4095, 24'hFFFFFF));
				1: apply_config(road(0, 1, 1, -16777216, 0, 0));
				default: apply_config(random_road_cfg());
			endcase
			sender_eager   = ($urandom_range(3) == 0);
			receiver_eager = ($urandom_range(3) == 0);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				scan_len = $urandom_range(8, 1);
				for (k = 0; k < scan_len; k++)
					send_obstacle(random_obstacle(k == scan_len - 1));
				sent += scan_len;
			end
			wait_idle();
		end
		sender_eager   = 1'b0;
		receiver_eager = 1'b0;
	endtask

	// The output is held off while scans keep coming, so the result register
	// fills and the input side has to stall.
	task automatic test_output_stall();
		int unsigned n;
		apply_config(road(1, 1024, 1778062, 0, 512, 24'hFFFFFF));
		hold_request = HOLD_CYCLES;
		for (n = 0; n < 24; n++)
			send_obstacle(random_obstacle(n % 2 == 1));
		wait_idle();
	endtask

	initial begin : result_checker
		int unsigned gap, held;
		out_item_t   want;
		wait (arst_n);
		forever begin
			if (hold_request > 0) begin
				out_ready <= 1'b0;
				held = 0;
				while (held < hold_request) begin
					@(posedge clk);
					held++;
				end
				hold_request = 0;
			end else begin
				gap = receiver_eager ? 0 : $urandom_range(14);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_checked++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with none expected: found %0d id %0d dist %0d",
					out_data.found, out_data.nearest_id, out_data.nearest_distance));
			end else begin
				want = expected_results.pop_front();
				if (out_data.found !== want.found)
					report_mismatch($sformatf("found got %0d expected %0d",
						out_data.found, want.found));
				if (out_data.nearest_id !== want.nearest_id)
					report_mismatch($sformatf("nearest_id got %0d expected %0d",
						out_data.nearest_id, want.nearest_id));
				if (out_data.nearest_distance !== want.nearest_distance)
					report_mismatch($sformatf("nearest_distance got %0d expected %0d",
						out_data.nearest_distance, want.nearest_distance));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : test_sequence
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_lane_limits();
		test_field_extremes();
		test_outer_lane_wrap();
		test_tie_first_wins();
		test_zero_track_length();
		test_zero_lane_width();
		test_search_range_limits();
		test_spare_index();
		test_random_scans();
		test_output_stall();
		wait_idle();
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("Checked %0d scan results from %0d obstacles under %0d register settings.",
			results_checked, obstacles_sent, settings_applied);
		$display("Covered lane limits, field extremes, ties, wraparound, degenerate sizes"
			, " and a stalled output.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
